// ===== rtl/sorted_table_binary_search_macros.svh =====
// ----------------------------------------------------------------------------
// sorted table search assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STB_ASSERT_SAME(label, ante, cons, msg)
`define STB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/stb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int BND_W       = ADDR_W + 1;
  localparam int CNT_W       = 9;
  localparam int POS_W       = 8;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic search_start;
    logic probe_step;
    logic res_capture;
  } stb_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } stb_status_t;

endpackage

// ===== rtl/stb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ctrl
// search sequencer: request handshake, probe loop control, output valid
// ----------------------------------------------------------------------------
module stb_ctrl
  import stb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output stb_cmd_t    cmd_o,
  input  stb_status_t status_i
);

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;
  logic   finish;

  always_comb begin
    cmd_o    = '0;
    accept   = in_valid_i && (state_q == ST_IDLE);
    out_free = !out_valid_q || !out_stall_i;
    finish   = status_i.hit || status_i.last;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_wr      = accept && (action_i == ACT_LOAD);
        cmd_o.search_start = accept && (action_i == ACT_SEARCH);
      end
      ST_PROBE: begin
        cmd_o.probe_step  = !finish;
        cmd_o.res_capture = finish && out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.res_capture || (out_valid_q && out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.search_start) begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (cmd_o.res_capture) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/stb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_dp
// table memories, search bounds, key compare and result register
// ----------------------------------------------------------------------------
module stb_dp
  import stb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stb_cmd_t           cmd_i,
  output stb_status_t        status_o,
  input  logic               cfg_valid_i,
  input  logic [CNT_W-1:0]   cfg_entry_count_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic signed [KEY_W-1:0] entry_key_i,
  input  logic [PAY_W-1:0]   entry_payload_i,
  input  logic signed [KEY_W-1:0] search_key_i,
  output logic               found_o,
  output logic [PAY_W-1:0]   found_payload_o,
  output logic [POS_W-1:0]   found_position_o
);

  // floor((low + high) / 2) with high = hi_x - 1, hi_x exclusive bound
  function automatic logic [ADDR_W-1:0] mid_of(input logic [BND_W-1:0] lo,
                                               input logic [BND_W-1:0] hx);
    logic [BND_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hx} - (BND_W+1)'(1);
    return sum[ADDR_W:1];
  endfunction

  logic [CNT_W-1:0]  count_q;
  logic [BND_W-1:0]  count_sat;
  logic [BND_W-1:0]  low_q, hi_q, low_n, hi_n;
  logic [ADDR_W-1:0] mid_q, raddr;
  logic              empty_q;
  logic [KEY_W-1:0]  skey_q;
  logic [KEY_W-1:0]  rd_key;
  logic [PAY_W-1:0]  rd_pay;
  logic              key_eq, key_lt;
  logic              wr_en;
  logic              found_q;
  logic [PAY_W-1:0]  payload_q;
  logic [POS_W-1:0]  pos_q;

  assign count_sat = (count_q > CNT_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                     : BND_W'(count_q);

  assign wr_en = cmd_i.load_wr && (32'(position_i) < 32'(TABLE_DEPTH));

  stb_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(position_i)),
    .wdata_i (entry_key_i),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  stb_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_DEPTH)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(position_i)),
    .wdata_i (entry_payload_i),
    .raddr_i (raddr),
    .rdata_o (rd_pay)
  );

  assign key_eq = (rd_key == skey_q);
  assign key_lt = ($signed(skey_q) < $signed(rd_key));

  always_comb begin
    if (key_lt) begin
      low_n = low_q;
      hi_n  = {1'b0, mid_q};
    end else begin
      low_n = {1'b0, mid_q} + BND_W'(1);
      hi_n  = hi_q;
    end
  end

  assign status_o.hit  = !empty_q && key_eq;
  assign status_o.last = empty_q || (low_n >= hi_n);

  // next probe address goes combinationally straight to the ram
  always_comb begin
    if (cmd_i.search_start) begin
      raddr = mid_of('0, count_sat);
    end else if (cmd_i.probe_step) begin
      raddr = mid_of(low_n, hi_n);
    end else begin
      raddr = mid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      empty_q <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_entry_count_i;
      end
      if (cmd_i.search_start) begin
        low_q   <= '0;
        hi_q    <= count_sat;
        mid_q   <= raddr;
        empty_q <= (count_sat == '0);
      end else if (cmd_i.probe_step) begin
        low_q <= low_n;
        hi_q  <= hi_n;
        mid_q <= raddr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_start) begin
      skey_q <= search_key_i;
    end
    if (cmd_i.res_capture) begin
      found_q   <= status_o.hit;
      payload_q <= status_o.hit ? rd_pay : '0;
      pos_q     <= status_o.hit ? POS_W'(mid_q) : '0;
    end
  end

  assign found_o          = found_q;
  assign found_payload_o  = payload_q;
  assign found_position_o = pos_q;

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// load request: taken while idle, writes one entry, gives no result
// search request: probes are serial, up to 9 probes for 256 entries, set by
//   the one read port of the key and payload rams (an empty table ends after its
//   first probe); in_stall_o stays high until the result is captured
// reset: entry_count cleared, controller idle, table contents undefined
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search
  import stb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel, always ready
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CNT_W-1:0]        cfg_entry_count_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [KEY_W-1:0] entry_key_i,
  input  logic [PAY_W-1:0]        entry_payload_i,
  input  logic signed [KEY_W-1:0] search_key_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    found_o,
  output logic [PAY_W-1:0]        found_payload_o,
  output logic [POS_W-1:0]        found_position_o
);

  stb_cmd_t    cmd;
  stb_status_t status;

  // the user must write the register only while no request is in flight; the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  // controller: idle/probe sequencing and the output valid flag
  stb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath: entry rams, low/high bounds, midpoint, compare, result register
  stb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_entry_count_i (cfg_entry_count_i),
    .position_i        (position_i),
    .entry_key_i       (entry_key_i),
    .entry_payload_i   (entry_payload_i),
    .search_key_i      (search_key_i),
    .found_o           (found_o),
    .found_payload_o   (found_payload_o),
    .found_position_o  (found_position_o)
  );

  // a load never produces a result
  `STB_ASSERT_NEXT(a_load_no_result, in_valid_i && !in_stall_o && (action_i == ACT_LOAD) && !out_valid_o, !out_valid_o, "load request produced a result")

  // a search keeps the request side busy while probing
  `STB_ASSERT_NEXT(a_search_busy, in_valid_i && !in_stall_o && (action_i == ACT_SEARCH), in_stall_o, "search accepted without going busy")

  // results are only captured into a free output register
  `STB_ASSERT_SAME(a_capture_free, cmd.res_capture, !out_valid_o || !out_stall_i, "result overwrote a stalled output")

  // a new result only appears after a capture
  `STB_ASSERT_SAME(a_valid_from_capture, $rose(out_valid_o), $past(cmd.res_capture), "output valid rose without a capture")

endmodule
